// ===== rtl/register_driven_pixel_writer_assert.svh =====
// Assertion macros for the pixel writer RTL.
// Included by the modules that carry checks; no other dependencies.
`ifndef REGISTER_DRIVEN_PIXEL_WRITER_ASSERT_SVH
`define REGISTER_DRIVEN_PIXEL_WRITER_ASSERT_SVH
`ifndef SYNTH
`define RDPW_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RDPW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RDPW_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define RDPW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/rdpw_pkg.sv =====
// Shared types and constants for the register-driven pixel writer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rdpw_pkg;
  localparam logic [1:0] CMD_RREAD = 2'd0;
  localparam logic [1:0] CMD_RWRITE = 2'd1;
  localparam logic [1:0] CMD_PREAD = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam int NUM_REGS = 24;
  localparam logic [4:0] R_XCUR = 5'd1;
  localparam logic [4:0] R_CLRX = 5'd2;
  localparam logic [4:0] R_YCUR = 5'd6;
  localparam logic [4:0] R_DATA = 5'd8;
  localparam logic [4:0] R_PLOTX = 5'd9;
  localparam logic [4:0] R_DATADN = 5'd10;
  localparam logic [4:0] R_DATART = 5'd13;
  localparam logic [4:0] R_PLOTY = 5'd14;
  localparam logic [4:0] R_DEST = 5'd16;
  localparam logic [4:0] R_MODE = 5'd17;
  localparam logic [4:0] R_COLOURS = 5'd18;
  localparam logic [4:0] R_CTRL = 5'd19;
  localparam logic [4:0] R_TICK = 5'd20;

  // Work kinds handed from front to back.
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_EXPAND = 2'd1,
    JOB_MOVE = 2'd2,
    JOB_PREAD = 2'd3
  } job_kind_t;

  // One queued job: everything the back end needs, snapshotted at issue.
  typedef struct packed {
    job_kind_t kind;
    logic [15:0] px;      // first column (already scaled, wrapped)
    logic [15:0] y;
    logic [15:0] dy;      // line move destination
    logic [15:0] data;    // aligned so the first pixel is in the top bits
    logic [4:0] count;    // pixels/columns minus one
    logic [2:0] bpp;      // 1, 2 or 4
    logic dbl;            // 40-column doubling
    logic xr;             // xor drawing
    logic [3:0] fg;
    logic [3:0] bg;
    logic [15:0] result;  // result for items without a pixel read
  } job_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_RD, BK_WR, BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

// ===== rtl/register_driven_pixel_writer.sv =====
// Register-driven pixel writer: 24 word registers and a 4-bit pixel store.
// Work per item: none in the store for register items, one store read for a pixel
// read, and for a draw a read-modify-write per pixel write (one store port), at most 16 writes.
// Flow: the back end starts a job only once the previous result is popped; the
// queue holds two jobs, the one in work included. Reset: synchronous, active low; a
// sweep over all SCREEN_W*SCREEN_H pixels then clears the pixel store before any job runs.
`timescale 1ns / 1ps
`default_nettype none
module register_driven_pixel_writer #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire logic [1:0] in_cmd,
  input  wire logic [4:0] in_reg_index,
  input  wire logic [15:0] in_write_data,
  input  wire logic [9:0] in_read_x,
  input  wire logic [8:0] in_read_y,
  output logic empty,
  input  wire logic pop,
  output logic [15:0] out_read_data
);
  rdpw_pkg::job_t fj, qj;
  logic fv, qfull, qempty, qpop;

  // Front: update registers on accept, hand a job to the queue.
  rdpw_front u_front (
    .clk, .rst_n, .in_valid(push), .in_stall(full), .cmd(in_cmd),
    .reg_index(in_reg_index), .write_data(in_write_data), .read_x(in_read_x),
    .read_y(in_read_y), .job_valid(fv), .job_full(qfull), .job(fj)
  );

  // Hold jobs so the front can run ahead of the drawing engine.
  rdpw_queue u_queue (
    .clk, .rst_n, .push(fv), .din(fj), .full(qfull), .pop(qpop),
    .empty(qempty), .dout(qj)
  );

  // Back: carry out pixel work and present one result transaction per item.
  rdpw_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
    .clk, .rst_n, .job_empty(qempty), .job(qj), .job_pop(qpop),
    .out_empty(empty), .out_pop(pop), .out_read_data
  );
endmodule
`default_nettype wire

// ===== rtl/rdpw_front.sv =====
// Front end: register file, command decode, job build.
// Depends on rdpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdpw_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [4:0] reg_index,
  input  wire logic [15:0] write_data,
  input  wire logic [9:0] read_x,
  input  wire logic [8:0] read_y,
  output logic job_valid,
  input  wire logic job_full,
  output rdpw_pkg::job_t job
);
  logic [15:0] regs_r [rdpw_pkg::NUM_REGS];
  logic [15:0] regs_nxt [rdpw_pkg::NUM_REGS];
  logic [15:0] dx, dy_c, ddata, mr, cr;
  logic do_draw, is80, acc;
  logic [2:0] mode;
  logic [7:0] msk;
  rdpw_pkg::job_t j;

  assign in_stall = job_full;
  assign acc = in_valid && !job_full;
  assign job_valid = acc;
  assign job = j;

  always_comb begin
    regs_nxt = regs_r;
    do_draw = 1'b0;
    dx = regs_r[rdpw_pkg::R_XCUR];
    dy_c = regs_r[rdpw_pkg::R_YCUR];
    ddata = write_data;
    is80 = regs_r[rdpw_pkg::R_CTRL][4];
    mode = regs_r[rdpw_pkg::R_MODE][2:0];
    cr = 16'd0;
    msk = 8'd0;
    j = '0;
    j.kind = rdpw_pkg::JOB_NONE;
    j.dbl = !is80;
    j.xr = regs_r[rdpw_pkg::R_MODE][3];
    j.fg = regs_r[rdpw_pkg::R_COLOURS][3:0];
    j.bg = regs_r[rdpw_pkg::R_COLOURS][7:4];
    j.dy = regs_r[rdpw_pkg::R_DEST];
    unique case (cmd)
      rdpw_pkg::CMD_RREAD: begin
        if (reg_index < 5'(rdpw_pkg::NUM_REGS)) j.result = regs_r[reg_index];
      end
      rdpw_pkg::CMD_PREAD: begin
        j.kind = rdpw_pkg::JOB_PREAD;
        j.px = {6'd0, read_x};
        j.y = {7'd0, read_y};
      end
      rdpw_pkg::CMD_TICK: begin
        cr = regs_r[rdpw_pkg::R_TICK] + 16'd1;
        if (cr[3:0] > 4'hA) cr[3:0] = 4'h0;
        regs_nxt[rdpw_pkg::R_TICK] = cr;
        j.result = cr;
      end
      default: begin
        if (reg_index < 5'(rdpw_pkg::NUM_REGS)) begin
          regs_nxt[reg_index] = write_data;
          case (reg_index)
            rdpw_pkg::R_CLRX: begin
              regs_nxt[rdpw_pkg::R_XCUR] = 16'd0;
              regs_nxt[rdpw_pkg::R_YCUR] = regs_r[rdpw_pkg::R_YCUR] + 16'd1;
            end
            rdpw_pkg::R_DATA: do_draw = 1'b1;
            rdpw_pkg::R_PLOTX: begin
              regs_nxt[rdpw_pkg::R_XCUR] = is80 ? write_data : {1'b0, write_data[15:1]};
              dx = write_data;
              ddata = {12'd0, j.fg};
              do_draw = 1'b1;
            end
            rdpw_pkg::R_DATADN: begin
              do_draw = 1'b1;
              regs_nxt[rdpw_pkg::R_YCUR] = regs_r[rdpw_pkg::R_YCUR] + 16'd1;
            end
            rdpw_pkg::R_DATART: begin
              dx = regs_r[rdpw_pkg::R_XCUR] + 16'd1;
              regs_nxt[rdpw_pkg::R_XCUR] = dx;
              do_draw = 1'b1;
            end
            rdpw_pkg::R_PLOTY: begin
              regs_nxt[rdpw_pkg::R_YCUR] = is80 ? write_data : {1'b0, write_data[15:1]};
              dy_c = write_data;
              ddata = {12'd0, j.fg};
              do_draw = 1'b1;
            end
            default: ;
          endcase
        end
      end
    endcase
    // classify the draw into an expand/move job
    msk = ddata[7:0] & ddata[15:8];
    mr = {msk, 8'd0};
    if (do_draw) begin
      j.kind = rdpw_pkg::JOB_EXPAND;
      j.y = dy_c;
      if (mode == 3'd3 || mode == 3'd7) begin
        // plot FG at (x, y), no doubling
        j.px = dx; j.count = 5'd0; j.bpp = 3'd4; j.dbl = 1'b0;
        j.data = {j.fg, 12'd0};
      end else if (mode == 3'd5) begin
        j.kind = rdpw_pkg::JOB_MOVE;
        j.px = is80 ? {dx[12:0], 3'd0} : {dx[11:0], 4'd0};
        j.count = is80 ? 5'd7 : 5'd15;
      end else if (is80) begin
        case (mode)
          3'd0: begin j.px = {dx[11:0], 4'd0}; j.count = 5'd15; j.bpp = 3'd1; j.data = ddata; end
          3'd4: begin j.px = {dx[13:0], 2'd0}; j.count = 5'd3; j.bpp = 3'd2; j.data = mr; end
          3'd6: begin j.px = {dx[12:0], 3'd0}; j.count = 5'd7; j.bpp = 3'd2; j.data = ddata; end
          default: begin
            j.px = {dx[12:0], 3'd0}; j.count = 5'd7; j.bpp = 3'd1;
            j.data = {ddata[7:0], 8'd0};
          end
        endcase
      end else begin
        case (mode)
          3'd1: begin j.px = {dx[13:0], 2'd0}; j.count = 5'd3; j.bpp = 3'd2;
                      j.data = {ddata[7:0], 8'd0}; end
          3'd4: begin j.px = {dx[14:0], 1'd0}; j.count = 5'd1; j.bpp = 3'd4; j.data = mr; end
          3'd6: begin j.px = {dx[13:0], 2'd0}; j.count = 5'd3; j.bpp = 3'd4; j.data = ddata; end
          default: begin
            j.px = {dx[12:0], 3'd0}; j.count = 5'd7; j.bpp = 3'd1;
            j.data = {ddata[7:0], 8'd0};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rdpw_pkg::NUM_REGS; i++) regs_r[i] <= 16'd0;
    end else if (acc) begin
      regs_r <= regs_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rdpw_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on rdpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdpw_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rdpw_pkg::job_t din,
  output logic full,
  input  wire logic pop,
  output logic empty,
  output rdpw_pkg::job_t dout
);
  rdpw_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= !wp_r;
      if (pop && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  `include "register_driven_pixel_writer_assert.svh"
  `RDPW_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3, "queue count overflow")
  `RDPW_ASSERT_IMPL(a_full_hold, clk, rst_n, (full && !pop) |=> full, "full dropped without pop")
  `RDPW_ASSERT_IMPL(a_empty_hold, clk, rst_n, (empty && !push) |=> empty, "empty left without push")
endmodule
`default_nettype wire

// ===== rtl/rdpw_back.sv =====
// Back end: pixel store, clearing sweep, per-pixel read-modify-write sequencer.
// Depends on rdpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdpw_back #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_empty,
  input  wire rdpw_pkg::job_t job,
  output logic job_pop,
  output logic out_empty,
  input  wire logic out_pop,
  output logic [15:0] out_read_data
);
  localparam int DEPTH = SCREEN_W * SCREEN_H;
  localparam int AW = $clog2(DEPTH);

  logic [3:0] mem [DEPTH];
  logic [3:0] rdat_r;
  rdpw_pkg::bk_state_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [4:0] i_r, i_nxt;
  logic half_r, half_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] sh_r, sh_nxt;
  logic [15:0] res_r, res_nxt;
  logic ov_r, ov_nxt;
  logic [15:0] col_x;
  logic inb, we;
  logic [AW-1:0] raddr, waddr;
  logic [3:0] wdat, colour;
  logic [31:0] ra32, wa32;

  // current pixel column and colour
  always_comb begin
    if (job.kind == rdpw_pkg::JOB_EXPAND && job.dbl) col_x = {col_r[14:0], half_r};
    else col_x = col_r;
    case (job.bpp)
      3'd1: colour = sh_r[15] ? job.fg : job.bg;
      3'd2: colour = {2'b00, sh_r[15:14]};
      default: colour = sh_r[15:12];
    endcase
    inb = 1'b0;
    ra32 = 32'd0;
    wa32 = 32'd0;
    case (job.kind)
      rdpw_pkg::JOB_PREAD: begin
        inb = 32'(job.px) < 32'(SCREEN_W) && 32'(job.y) < 32'(SCREEN_H);
        ra32 = 32'(job.y[9:0]) * 32'(SCREEN_W) + 32'(job.px[10:0]);
      end
      rdpw_pkg::JOB_MOVE: begin
        inb = 32'(col_x) < 32'(SCREEN_W) && 32'(job.y) < 32'(SCREEN_H)
              && 32'(job.dy) < 32'(SCREEN_H);
        ra32 = 32'(job.y[9:0]) * 32'(SCREEN_W) + 32'(col_x[10:0]);
        wa32 = 32'(job.dy[9:0]) * 32'(SCREEN_W) + 32'(col_x[10:0]);
      end
      default: begin
        inb = 32'(col_x) < 32'(SCREEN_W) && 32'(job.y) < 32'(SCREEN_H);
        ra32 = 32'(job.y[9:0]) * 32'(SCREEN_W) + 32'(col_x[10:0]);
        wa32 = ra32;
      end
    endcase
    raddr = ra32[AW-1:0];
    waddr = wa32[AW-1:0];
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; i_nxt = i_r; half_nxt = half_r;
    col_nxt = col_r; sh_nxt = sh_r; res_nxt = res_r; ov_nxt = ov_r;
    job_pop = 1'b0; we = 1'b0; wdat = 4'd0;
    unique case (st_r)
      rdpw_pkg::BK_CLEAR: begin
        we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == 32'(DEPTH - 1)) st_nxt = rdpw_pkg::BK_IDLE;
      end
      rdpw_pkg::BK_IDLE: begin
        if (!job_empty && !ov_r) begin
          i_nxt = 5'd0; half_nxt = 1'b0; col_nxt = job.px; sh_nxt = job.data;
          res_nxt = job.result;
          st_nxt = (job.kind == rdpw_pkg::JOB_NONE) ? rdpw_pkg::BK_DONE
                                                     : rdpw_pkg::BK_RD;
        end
      end
      rdpw_pkg::BK_RD: st_nxt = rdpw_pkg::BK_WR;  // read data lands in rdat_r
      rdpw_pkg::BK_WR: begin
        if (job.kind == rdpw_pkg::JOB_PREAD) begin
          res_nxt = inb ? {12'd0, rdat_r} : 16'd0;
          st_nxt = rdpw_pkg::BK_DONE;
        end else begin
          we = inb;
          if (job.kind == rdpw_pkg::JOB_MOVE) wdat = rdat_r;
          else wdat = job.xr ? (rdat_r ^ colour) : colour;
          st_nxt = rdpw_pkg::BK_RD;
          if (job.kind == rdpw_pkg::JOB_EXPAND && job.dbl && !half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            col_nxt = col_r + 16'd1;
            i_nxt = i_r + 5'd1;
            case (job.bpp)
              3'd1: sh_nxt = {sh_r[14:0], 1'b0};
              3'd2: sh_nxt = {sh_r[13:0], 2'b0};
              default: sh_nxt = {sh_r[11:0], 4'b0};
            endcase
            if (i_r == job.count) st_nxt = rdpw_pkg::BK_DONE;
          end
        end
      end
      rdpw_pkg::BK_DONE: begin
        job_pop = 1'b1; ov_nxt = 1'b1; st_nxt = rdpw_pkg::BK_IDLE;
      end
      default: st_nxt = rdpw_pkg::BK_IDLE;
    endcase
    if (out_pop && ov_r) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    rdat_r <= mem[raddr];
    if (we) mem[(st_r == rdpw_pkg::BK_CLEAR) ? clr_r : waddr] <= wdat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rdpw_pkg::BK_CLEAR; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
    end
    i_r <= i_nxt; half_r <= half_nxt; col_r <= col_nxt; sh_r <= sh_nxt; res_r <= res_nxt;
  end

  assign out_empty = !ov_r;
  assign out_read_data = res_r;

  `include "register_driven_pixel_writer_assert.svh"
  `RDPW_ASSERT_NEVER(a_pop_one, clk, rst_n, job_pop && job_empty, "back pops empty queue")
  `RDPW_ASSERT_IMPL(a_done_out, clk, rst_n, (st_r == rdpw_pkg::BK_DONE) |=> ov_r, "result lost")
  `RDPW_ASSERT_NEVER(a_ov_start, clk, rst_n, ov_r && st_r == rdpw_pkg::BK_RD && $past(st_r) == rdpw_pkg::BK_IDLE, "job started over pending result")
endmodule
`default_nettype wire
